// File: sv/top_k_magnitude_average_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the top-k magnitude average block
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOP_K_MAGNITUDE_AVERAGE_TOP_MACROS_SVH
`define TOP_K_MAGNITUDE_AVERAGE_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define TKMA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TKMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tkma_pkg.sv
// ----------------------------------------------------------------------------
// tkma_pkg
// Shared widths, reset values, magnitude function and divider status type.
// ----------------------------------------------------------------------------
package tkma_pkg;

  localparam int SAMPLE_W     = 32;
  localparam int KEEP_W       = 5;
  localparam int HELD_W       = 5;
  localparam int MAX_KEEP_DEF = 16;

  localparam logic [KEEP_W-1:0]   KEEP_RESET = 5'd16;
  localparam logic [SAMPLE_W-1:0] MOST_NEG   = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0] MAX_POS    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } tkma_div_stat_t;

  // absolute value, saturated for the most negative sample
  function automatic logic [SAMPLE_W-1:0] tkma_mag(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] res;
    if (raw == MOST_NEG) begin
      res = MAX_POS;
    end else if (raw[SAMPLE_W-1]) begin
      res = ~raw + 32'd1;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

// File: sv/tkma_store.sv
// ----------------------------------------------------------------------------
// tkma_store
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tkma_store #(
  parameter int DEPTH = tkma_pkg::MAX_KEEP_DEF,
  parameter int AW    = 4
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [tkma_pkg::SAMPLE_W-1:0] wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [tkma_pkg::SAMPLE_W-1:0] rd_data
);

  logic [tkma_pkg::SAMPLE_W-1:0] mem_r [DEPTH];
  logic [tkma_pkg::SAMPLE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/tkma_div.sv
// ----------------------------------------------------------------------------
// tkma_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tkma_div #(
  parameter int DW = 37,
  parameter int VW = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DW-1:0]            dividend,
  input  logic [VW-1:0]            divisor,
  output tkma_pkg::tkma_div_stat_t stat,
  output logic [DW-1:0]            quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dq_r;
  logic [VW-1:0]    rem_r;
  logic [VW-1:0]    dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VW:0]      sh;
  logic             ge;
  logic [VW-1:0]    rem_nxt;

  always_comb begin
    sh      = {rem_r, dq_r[DW-1]};
    ge      = sh >= {1'b0, dvs_r};
    rem_nxt = ge ? VW'(sh - {1'b0, dvs_r}) : sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dq_r   <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= CNT_W'(DW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        dq_r  <= {dq_r[DW-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

// File: sv/top_k_magnitude_average_top.sv
// ----------------------------------------------------------------------------
// top_k_magnitude_average_top
// Keeps the samples of greatest magnitude and reports their truncated mean.
// ----------------------------------------------------------------------------
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | in_tdata: sample_value
// out_    | out | out_tvalid / out_tready| out_tdata: average_value, entries_held
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_data: keep_count
//
// One sample runs a store scan of one entry per cycle, then the serial divider at one
// quotient bit per cycle. in_tready is high only while the sequencer is idle.
// A finished result sits in the output register while the next sample is taken.
// Reset clears the held count and sets keep_count to 16; the store is not cleared.
// ----------------------------------------------------------------------------
`include "top_k_magnitude_average_top_macros.svh"

module top_k_magnitude_average_top #(
  parameter int MAX_KEEP = tkma_pkg::MAX_KEEP_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [31:0]                 in_tdata,   // [31:0] sample_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [39:0]                 out_tdata,  // [31:0] average_value, [36:32] entries_held
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tkma_pkg::KEEP_W-1:0] cfg_data    // keep_count
);

  localparam int SW  = tkma_pkg::SAMPLE_W;
  localparam int IW  = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CW  = $clog2(MAX_KEEP + 1);
  localparam int EW  = (CW > tkma_pkg::KEEP_W) ? CW : tkma_pkg::KEEP_W;
  localparam int AW  = SW + 1 + $clog2(MAX_KEEP);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIX, ST_SUB, ST_DIVS, ST_DIVW, ST_OUT
  } state_t;

  state_t                        state_r;
  logic [tkma_pkg::KEEP_W-1:0]   keep_r;
  logic [CW-1:0]                 held_r;
  logic [SW-1:0]                 sample_r;
  logic [AW-1:0]                 sum_r;
  logic [IW-1:0]                 idx_r;
  logic                          pend_r;
  logic                          first_r;
  logic [SW-1:0]                 least_mag_r;
  logic [SW-1:0]                 least_val_r;
  logic [IW-1:0]                 least_idx_r;
  logic [IW-1:0]                 pidx_r;
  logic                          neg_r;
  logic                          out_valid_r;
  logic [SW-1:0]                 avg_r;
  logic [tkma_pkg::HELD_W-1:0]   out_held_r;

  logic [EW-1:0]                 keep_e;
  logic [EW-1:0]                 eff;
  logic                          append;
  logic                          replace;
  logic                          last_issue;
  logic [SW-1:0]                 rd_data;
  logic [SW-1:0]                 rd_mag;
  logic                          take_least;
  logic                          mem_wr;
  logic [IW-1:0]                 mem_wr_addr;
  logic                          div_start;
  logic [AW-1:0]                 div_dividend;
  tkma_pkg::tkma_div_stat_t      div_stat;
  logic [AW-1:0]                 div_q;
  logic [SW-1:0]                 avg_nxt;

  always_comb begin
    keep_e = EW'(keep_r);
    if (keep_e == '0) begin
      eff = EW'(1);
    end else if (keep_e > EW'(MAX_KEEP)) begin
      eff = EW'(MAX_KEEP);
    end else begin
      eff = keep_e;
    end
    append      = EW'(held_r) < eff;
    replace     = !append && (tkma_pkg::tkma_mag(sample_r) > least_mag_r);
    last_issue  = (CW'(idx_r) + CW'(1)) == held_r;
    rd_mag      = tkma_pkg::tkma_mag(rd_data);
    take_least  = first_r || (rd_mag < least_mag_r);
    mem_wr      = (state_r == ST_FIX) && (append || replace);
    mem_wr_addr = append ? IW'(held_r) : least_idx_r;
    div_start   = state_r == ST_DIVS;
    div_dividend = sum_r[AW-1] ? (~sum_r + AW'(1)) : sum_r;
    avg_nxt     = neg_r ? (~div_q[SW-1:0] + SW'(1)) : div_q[SW-1:0];
  end

  tkma_store #(
    .DEPTH (MAX_KEEP),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (mem_wr_addr),
    .wr_data (sample_r),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  tkma_div #(
    .DW (AW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (held_r),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      keep_r      <= tkma_pkg::KEEP_RESET;
      held_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        keep_r <= cfg_data;
      end
      if (out_valid_r && out_tready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_SCAN || state_r == ST_DRAIN) && pend_r) begin
        sum_r   <= sum_r + AW'(signed'(rd_data));
        first_r <= 1'b0;
        if (take_least) begin
          least_mag_r <= rd_mag;
          least_val_r <= rd_data;
          least_idx_r <= pidx_r;
        end
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            sample_r <= in_tdata;
            sum_r    <= '0;
            idx_r    <= '0;
            pend_r   <= 1'b0;
            first_r  <= 1'b1;
            state_r  <= (held_r == '0) ? ST_FIX : ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend_r <= 1'b1;
          pidx_r <= idx_r;
          idx_r  <= idx_r + 1'b1;
          if (last_issue) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          pend_r  <= 1'b0;
          state_r <= ST_FIX;
        end
        ST_FIX: begin
          if (append || replace) begin
            sum_r <= sum_r + AW'(signed'(sample_r));
          end
          if (append) begin
            held_r <= held_r + 1'b1;
          end
          state_r <= replace ? ST_SUB : ST_DIVS;
        end
        ST_SUB: begin
          sum_r   <= sum_r - AW'(signed'(least_val_r));
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          neg_r   <= sum_r[AW-1];
          state_r <= ST_DIVW;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            avg_r       <= avg_nxt;
            out_held_r  <= tkma_pkg::HELD_W'(held_r);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = state_r == ST_IDLE;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_held_r, avg_r};

  `TKMA_ASSERT_SAME(a_held_bound, 1'b1, held_r <= CW'(MAX_KEEP),
    "held count above store depth")
  `TKMA_ASSERT_NEXT(a_accept_starts, in_tvalid && in_tready,
    state_r == ST_SCAN || state_r == ST_FIX, "sample transfer did not start a scan")
  `TKMA_ASSERT_SAME(a_div_busy_wait, div_stat.busy, state_r == ST_DIVW,
    "divider running outside its wait state")
  `TKMA_ASSERT_SAME(a_out_nonempty, out_tvalid, held_r != '0,
    "result presented with an empty store")

endmodule
